FILE: hdl/ubxp_pkg.sv
// Shared types and constants for the NAV-PVT frame parser.
package ubxp_pkg;

  localparam int unsigned MAX_PAYLOAD = 128;
  localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD);

  localparam logic [7:0]  MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);
  localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND   = 8'h62;
  localparam logic [7:0]  CLASS_NAV     = 8'h01;
  localparam logic [7:0]  ID_PVT        = 8'h07;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  // Request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Payload offsets that feed the report, one captured byte each
  localparam int unsigned NUM_TAPS = 25;
  localparam logic [LEN_W-1:0] TAP_OFF [NUM_TAPS] = '{
    LEN_W'(4),  LEN_W'(5),  LEN_W'(6),  LEN_W'(7),  LEN_W'(8),
    LEN_W'(9),  LEN_W'(10), LEN_W'(20), LEN_W'(23), LEN_W'(24),
    LEN_W'(25), LEN_W'(26), LEN_W'(27), LEN_W'(28), LEN_W'(29),
    LEN_W'(30), LEN_W'(31), LEN_W'(36), LEN_W'(37), LEN_W'(38),
    LEN_W'(39), LEN_W'(60), LEN_W'(61), LEN_W'(62), LEN_W'(63)
  };

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] year;
    logic [7:0]         month;
    logic [7:0]         day;
    logic [7:0]         hour;
    logic [7:0]         minute;
    logic [7:0]         second;
    logic [7:0]         fix_type;
    logic [7:0]         sat_count;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] altitude;
    logic signed [31:0] gnd_speed;
  } pvt_item_t;

endpackage

FILE: hdl/ubxp_if.sv
// Valid/ready channel interfaces for parser input items and reports.
interface ubxp_in_if;
  logic                valid;
  logic                ready;
  ubxp_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ubxp_out_if;
  logic                valid;
  logic                ready;
  ubxp_pkg::pvt_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ubx_nav_pvt_frame_parser.sv
// NAV-PVT frame parser with fix-loss timeout: top level.
//
// Takes one input transaction per clock: a received byte or a 1 ms tick. Each
// item is handled in the cycle it is accepted, and any report it causes enters
// the two-entry output buffer at the next clock edge. Reports leave through it,
// so rx_i.ready drops only when both entries hold reports that pvt_o has not
// taken; otherwise one item is accepted every cycle. Only the payload bytes that
// feed the report are kept, in registers, so no clearing pass runs after reset.
// The user must write timeout_q via cfg_we_i/cfg_wdata_i only while idle.
module ubx_nav_pvt_frame_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  ubxp_in_if.sink           rx_i,
  ubxp_out_if.source        pvt_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);

  localparam int unsigned LEN_W = ubxp_pkg::LEN_W;
  localparam int unsigned NUM_TAPS = ubxp_pkg::NUM_TAPS;

  typedef enum logic [8:0] {
    ST_HUNT    = 9'b000000001,
    ST_SYNC2   = 9'b000000010,
    ST_CLASS   = 9'b000000100,
    ST_ID      = 9'b000001000,
    ST_LEN_LO  = 9'b000010000,
    ST_LEN_HI  = 9'b000100000,
    ST_PAYLOAD = 9'b001000000,
    ST_CK_A    = 9'b010000000,
    ST_CK_B    = 9'b100000000
  } parse_state_e;

  parse_state_e state_q, state_d;
  logic [7:0]   sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0]   sum_a_inc, sum_b_inc;
  logic [7:0]   class_q, class_d, id_q, id_d, ck_a_q, ck_a_d;
  logic [LEN_W-1:0] len_q, len_d, cnt_q, cnt_d;
  logic [7:0]   tap_q [NUM_TAPS];
  logic [7:0]   tap_d [NUM_TAPS];
  logic [15:0]  elapsed_q, elapsed_d;
  logic         to_rep_q, to_rep_d;
  logic [15:0]  timeout_q;
  ubxp_pkg::pvt_item_t held_q, held_d, tap_item, res_d;
  logic         res_v;
  logic [7:0]   rx_byte;
  logic         in_fire;

  ubxp_pkg::pvt_item_t out_q, skid_q;
  logic         out_valid_q, skid_valid_q, out_fire;

  assign rx_byte    = rx_i.data.rx_byte;
  assign rx_i.ready = !skid_valid_q;
  assign in_fire    = rx_i.valid && rx_i.ready;
  assign out_fire   = out_valid_q && pvt_o.ready;
  assign pvt_o.valid = out_valid_q;
  assign pvt_o.data  = out_q;

  assign sum_a_inc = sum_a_q + rx_byte;
  assign sum_b_inc = sum_b_q + sum_a_inc;

  always_comb begin
    tap_item.year         = {tap_q[1], tap_q[0]};
    tap_item.month        = tap_q[2];
    tap_item.day          = tap_q[3];
    tap_item.hour         = tap_q[4];
    tap_item.minute       = tap_q[5];
    tap_item.second       = tap_q[6];
    tap_item.fix_type     = tap_q[7];
    tap_item.sat_count    = tap_q[8];
    tap_item.longitude    = {tap_q[12], tap_q[11], tap_q[10], tap_q[9]};
    tap_item.latitude     = {tap_q[16], tap_q[15], tap_q[14], tap_q[13]};
    tap_item.altitude     = {tap_q[20], tap_q[19], tap_q[18], tap_q[17]};
    tap_item.gnd_speed    = {tap_q[24], tap_q[23], tap_q[22], tap_q[21]};
  end

  always_comb begin
    state_d   = state_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    class_d   = class_q;
    id_d      = id_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    ck_a_d    = ck_a_q;
    tap_d     = tap_q;
    elapsed_d = elapsed_q;
    to_rep_d  = to_rep_q;
    held_d    = held_q;
    res_v     = 1'b0;
    res_d     = held_q;
    if (in_fire) begin
      if (rx_i.data.req_type == ubxp_pkg::REQ_TICK) begin
        if (elapsed_q != 16'hFFFF) begin
          elapsed_d = elapsed_q + 16'd1;
        end
        if (elapsed_d > timeout_q && !to_rep_q) begin
          to_rep_d = 1'b1;
          res_v    = 1'b1;
        end
      end else begin
        unique case (state_q)
          ST_SYNC2: begin
            state_d = (rx_byte == ubxp_pkg::SYNC_SECOND) ? ST_CLASS : ST_HUNT;
          end
          ST_CLASS: begin
            class_d = rx_byte;
            sum_a_d = sum_a_inc;
            sum_b_d = sum_b_inc;
            state_d = ST_ID;
          end
          ST_ID: begin
            id_d    = rx_byte;
            sum_a_d = sum_a_inc;
            sum_b_d = sum_b_inc;
            state_d = ST_LEN_LO;
          end
          ST_LEN_LO: begin
            // drop an oversized frame; this is not a frame end
            if (rx_byte >= ubxp_pkg::MAX_PAYLOAD_B) begin
              sum_a_d = '0;
              sum_b_d = '0;
              state_d = ST_HUNT;
            end else begin
              len_d   = rx_byte[LEN_W-1:0];
              sum_a_d = sum_a_inc;
              sum_b_d = sum_b_inc;
              state_d = ST_LEN_HI;
            end
          end
          ST_LEN_HI: begin
            sum_a_d = sum_a_inc;
            sum_b_d = sum_b_inc;
            cnt_d   = '0;
            state_d = (len_q == '0) ? ST_CK_A : ST_PAYLOAD;
          end
          ST_PAYLOAD: begin
            if (cnt_q < len_q) begin
              for (int i = 0; i < NUM_TAPS; i++) begin
                if (cnt_q == ubxp_pkg::TAP_OFF[i]) begin
                  tap_d[i] = rx_byte;
                end
              end
              sum_a_d = sum_a_inc;
              sum_b_d = sum_b_inc;
              cnt_d   = cnt_q + LEN_W'(1);
              if (cnt_d == len_q) begin
                state_d = ST_CK_A;
              end
            end else begin
              state_d = ST_CK_A;
            end
          end
          ST_CK_A: begin
            ck_a_d  = rx_byte;
            state_d = ST_CK_B;
          end
          ST_CK_B: begin
            if (sum_a_q == ck_a_q && sum_b_q == rx_byte &&
                class_q == ubxp_pkg::CLASS_NAV && id_q == ubxp_pkg::ID_PVT) begin
              held_d          = tap_item;
              held_d.fix_type = '0;
              res_v           = 1'b1;
              res_d           = tap_item;
            end
            // frame end: restart hunting and the timeout
            state_d   = ST_HUNT;
            sum_a_d   = '0;
            sum_b_d   = '0;
            elapsed_d = '0;
            to_rep_d  = 1'b0;
          end
          default: begin
            state_d = (rx_byte == ubxp_pkg::SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_HUNT;
      sum_a_q   <= '0;
      sum_b_q   <= '0;
      class_q   <= '0;
      id_q      <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      ck_a_q    <= '0;
      elapsed_q <= '0;
      to_rep_q  <= 1'b0;
      held_q    <= '0;
      timeout_q <= ubxp_pkg::TIMEOUT_RESET;
      for (int i = 0; i < NUM_TAPS; i++) begin
        tap_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      sum_a_q   <= sum_a_d;
      sum_b_q   <= sum_b_d;
      class_q   <= class_d;
      id_q      <= id_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      ck_a_q    <= ck_a_d;
      elapsed_q <= elapsed_d;
      to_rep_q  <= to_rep_d;
      held_q    <= held_d;
      tap_q     <= tap_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Two-entry output buffer: out_q faces the sink, skid_q catches a report
  // made while out_q is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !out_fire) begin
      if (res_v) begin
        skid_valid_q <= 1'b1;
      end
    end else begin
      out_valid_q <= res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !out_fire) begin
      if (res_v) begin
        skid_q <= res_d;
      end
    end else if (res_v) begin
      out_q <= res_d;
    end
  end

endmodule

FILE: hdl/ubxp_checker.sv
// Port-level checks for the NAV-PVT frame parser, bound to the top level.
module ubxp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ubxp_pkg::pvt_item_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("report dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("report changed while stalled");

  a_rise_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("report appeared without an accepted transaction");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

endmodule

bind ubx_nav_pvt_frame_parser ubxp_checker u_ubxp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rx_i.valid),
  .in_ready_i  (rx_i.ready),
  .out_valid_i (pvt_o.valid),
  .out_ready_i (pvt_o.ready),
  .out_data_i  (pvt_o.data)
);

FILE: sim/testbench.sv
// Testbench for the NAV-PVT frame parser: directed rows, then random framed traffic.
`timescale 1ns / 100ps

module testbench;
  import ubxp_pkg::*;

  typedef enum logic [3:0] {
    ST_HUNT, ST_SYNC2, ST_CLASS, ST_ID, ST_LEN0, ST_LEN1, ST_PAYLOAD, ST_CKA, ST_CKB
  } parse_step_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx;
    logic       typed;
    logic       has_rpt;
    pvt_item_t  rpt;
  } stim_row_t;

  localparam pvt_item_t PVT_ZERO = '0;
  localparam int unsigned NUM_ROWS = 28;
  localparam int unsigned PHASE_ITEMS = 185;

  // Timeout is 0 for these rows; typed rows expect an all-zero report or none.
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{REQ_TICK, 8'h00, 1'b1, 1'b1, PVT_ZERO},
    '{REQ_BYTE, 8'hB5, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'hB5, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'h62, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'hB5, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'h62, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'h01, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'h07, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'h00, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'h00, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'h08, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'h19, 1'b1, 1'b1, PVT_ZERO},
    '{REQ_TICK, 8'hFF, 1'b1, 1'b1, PVT_ZERO},
    '{REQ_BYTE, 8'hB5, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'h62, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'h01, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'h07, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'hFF, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_TICK, 8'h00, 1'b1, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'hB5, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'h62, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'h05, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'hFF, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'h00, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'h00, 1'b0, 1'b0, PVT_ZERO},
    '{REQ_BYTE, 8'h04, 1'b0, 1'b0, PVT_ZERO}, '{REQ_BYTE, 8'h11, 1'b1, 1'b0, PVT_ZERO},
    '{REQ_TICK, 8'h5A, 1'b1, 1'b1, PVT_ZERO}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  ubxp_in_if  rx_if ();
  ubxp_out_if pvt_if ();

  ubx_nav_pvt_frame_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_if),
    .pvt_o      (pvt_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state
  parse_step_e pstep = ST_HUNT;
  logic [15:0] run_sum = '0;  // {sum_b, sum_a}
  logic [7:0]  frm_class = '0;
  logic [7:0]  frm_id = '0;
  logic [7:0]  pay_len = '0;
  logic [7:0]  pay_cnt = '0;
  logic [7:0]  chk_a = '0;
  logic [7:0]  pay_store [MAX_PAYLOAD] = '{default: '0};
  logic [15:0] tick_count = '0;
  logic        loss_reported = 1'b0;
  pvt_item_t   held_pvt = '0;
  logic [15:0] timeout_cfg = TIMEOUT_RESET;

  pvt_item_t pending_reports [$];
  int        items_sent = 0;
  int        reports_predicted = 0;
  int        mismatch_count = 0;
  bit        gap_on = 1'b1;
  bit        stall_on = 1'b1;

  function automatic logic [15:0] fletcher_next(input logic [15:0] s, input logic [7:0] b);
    logic [7:0] a;
    a = s[7:0] + b;
    return {s[15:8] + a, a};
  endfunction

  function automatic logic [31:0] store_word(input int unsigned off);
    return {pay_store[off+3], pay_store[off+2], pay_store[off+1], pay_store[off]};
  endfunction

  function automatic bit parse_item(input in_item_t it, output pvt_item_t rpt);
    logic [7:0] b;
    bit         hit;
    b = it.rx_byte;
    hit = 1'b0;
    rpt = '0;
    if (it.req_type == REQ_TICK) begin
      if (tick_count != 16'hFFFF) tick_count++;
      if (tick_count > timeout_cfg && !loss_reported) begin
        loss_reported = 1'b1;
        rpt = held_pvt;
        rpt.fix_type = '0;
        hit = 1'b1;
      end
    end else begin
      case (pstep)
        ST_SYNC2: pstep = (b == SYNC_SECOND) ? ST_CLASS : ST_HUNT;
        ST_CLASS: begin
          frm_class = b;
          run_sum = fletcher_next(run_sum, b);
          pstep = ST_ID;
        end
        ST_ID: begin
          frm_id = b;
          run_sum = fletcher_next(run_sum, b);
          pstep = ST_LEN0;
        end
        ST_LEN0: begin
          pay_len = b;
          run_sum = fletcher_next(run_sum, b);
          // drop oversize frames; not a frame end
          if (b >= MAX_PAYLOAD_B) begin
            pstep = ST_HUNT;
            run_sum = '0;
          end else begin
            pstep = ST_LEN1;
          end
        end
        ST_LEN1: begin
          run_sum = fletcher_next(run_sum, b);
          pay_cnt = '0;
          pstep = (pay_len == 0) ? ST_CKA : ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          if (pay_cnt < pay_len) begin
            pay_store[pay_cnt[LEN_W-1:0]] = b;
            run_sum = fletcher_next(run_sum, b);
            pay_cnt++;
            if (pay_cnt == pay_len) pstep = ST_CKA;
          end else begin
            pstep = ST_CKA;
          end
        end
        ST_CKA: begin
          chk_a = b;
          pstep = ST_CKB;
        end
        ST_CKB: begin
          if (run_sum[7:0] == chk_a && run_sum[15:8] == b &&
              frm_class == CLASS_NAV && frm_id == ID_PVT) begin
            held_pvt.year         = {pay_store[5], pay_store[4]};
            held_pvt.month        = pay_store[6];
            held_pvt.day          = pay_store[7];
            held_pvt.hour         = pay_store[8];
            held_pvt.minute       = pay_store[9];
            held_pvt.second       = pay_store[10];
            held_pvt.sat_count    = pay_store[23];
            held_pvt.longitude    = store_word(24);
            held_pvt.latitude     = store_word(28);
            held_pvt.altitude     = store_word(36);
            held_pvt.gnd_speed    = store_word(60);
            rpt = held_pvt;
            rpt.fix_type = pay_store[20];
            hit = 1'b1;
          end
          // any frame end restarts the tick count and re-arms the timeout
          pstep = ST_HUNT;
          run_sum = '0;
          tick_count = '0;
          loss_reported = 1'b0;
        end
        default: pstep = (b == SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
      endcase
    end
    return hit;
  endfunction

  function automatic string pvt_str(input pvt_item_t r);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d fix=%0d sats=%0d lon=%0d lat=%0d alt=%0d spd=%0d",
                     r.year, r.month, r.day, r.hour, r.minute, r.second, r.fix_type,
                     r.sat_count, r.longitude, r.latitude, r.altitude, r.gnd_speed);
  endfunction

  task automatic accept_item(input logic kind, input logic [7:0] b,
                             output bit hit, output pvt_item_t rpt);
    in_item_t it;
    it.req_type = kind;
    it.rx_byte = b;
    if (gap_on && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.data <= it;
    @(posedge clk_i);
    while (rx_if.ready !== 1'b1) @(posedge clk_i);
    items_sent++;
    hit = parse_item(it, rpt);
    if (hit) reports_predicted++;
  endtask

  task automatic send_item(input logic kind, input logic [7:0] b);
    bit        hit;
    pvt_item_t rpt;
    accept_item(kind, b, hit, rpt);
    if (hit) pending_reports.push_back(rpt);
  endtask

  // Hold the input channel idle until every predicted report has drained.
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    timeout_cfg = value;
  endtask

  // Mostly well-formed NAV-PVT frames; the rest are other frames, oversize
  // lengths, corrupted or truncated frames and line noise.
  task automatic send_frame();
    logic [7:0]  frame [$];
    logic [15:0] sum;
    logic [7:0]  len;
    int          pick;
    int          k;
    int          idx;
    int          tick_span;
    pick = $urandom_range(0, 99);
    if (pick >= 94) begin
      repeat ($urandom_range(1, 8))
        frame.push_back(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
    end else begin
      k = $urandom_range(0, 99);
      if (k < 55) len = 8'($urandom_range(0, 30));
      else if (k < 88) len = 8'($urandom_range(31, 70));
      else len = 8'($urandom_range(71, 127));
      if (pick >= 82 && pick < 88) len = 8'($urandom_range(MAX_PAYLOAD, 255));
      frame.push_back(SYNC_FIRST);
      frame.push_back(SYNC_SECOND);
      frame.push_back((pick >= 70 && pick < 82) ? 8'($urandom) : CLASS_NAV);
      frame.push_back((pick >= 70 && pick < 82) ? 8'($urandom_range(0, 15)) : ID_PVT);
      frame.push_back(len);
      frame.push_back(8'($urandom));
      if (len < MAX_PAYLOAD_B) begin
        sum = '0;
        for (int i = 2; i < 6; i++) sum = fletcher_next(sum, frame[i]);
        repeat (len) begin
          frame.push_back(8'($urandom));
          sum = fletcher_next(sum, frame[frame.size()-1]);
        end
        frame.push_back(sum[7:0]);
        frame.push_back(sum[15:8]);
        if (pick < 7) begin
          idx = $urandom_range(2, frame.size() - 1);
          frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (pick >= 88) begin
          k = $urandom_range(1, frame.size() - 1);
          while (frame.size() > k) void'(frame.pop_back());
        end
      end
    end
    foreach (frame[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(REQ_TICK, 8'($urandom));
      send_item(REQ_BYTE, frame[i]);
    end
    tick_span = (timeout_cfg <= 40) ? int'(timeout_cfg) + 8 : 12;
    if ($urandom_range(0, 1) == 1)
      repeat ($urandom_range(1, tick_span)) send_item(REQ_TICK, 8'($urandom));
  endtask

  initial begin : report_check
    pvt_item_t want;
    int        stall_left;
    stall_left = 0;
    pvt_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pvt_if.valid === 1'b1 && pvt_if.ready === 1'b1) begin
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected report: %s", pvt_str(pvt_if.data));
        end else begin
          want = pending_reports.pop_front();
          if (pvt_if.data !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("report mismatch, expected: %s", pvt_str(want));
              $display("                 actual:   %s", pvt_str(pvt_if.data));
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pvt_if.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        pvt_if.ready <= 1'b0;
      end else begin
        pvt_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    bit          hit;
    pvt_item_t   rpt;
    logic [15:0] phase_timeout [5];
    int          p_start;
    bit          paused;
    rx_if.valid <= 1'b0;
    rx_if.data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_timeout(16'd0);
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      accept_item(row.kind, row.rx, hit, rpt);
      if (row.typed) begin
        if (row.has_rpt) pending_reports.push_back(row.rpt);
      end else if (hit) begin
        pending_reports.push_back(rpt);
      end
    end

    phase_timeout[0] = 16'hFFFF;
    phase_timeout[1] = 16'($urandom_range(1, 12));
    phase_timeout[2] = 16'($urandom_range(13, 50));
    phase_timeout[3] = 16'd0;
    phase_timeout[4] = 16'($urandom_range(1, 40));
    paused = 1'b0;
    for (int p = 0; p < 5; p++) begin
      write_timeout(phase_timeout[p]);
      // first and last phases run without idling on either side
      gap_on = (p != 0 && p != 4);
      stall_on = gap_on;
      p_start = items_sent;
      while (items_sent - p_start < PHASE_ITEMS) begin
        if (p == 1 && !paused && items_sent - p_start >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        send_frame();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS ubx_nav_pvt_frame_parser");
    end else begin
      $display("FAIL ubx_nav_pvt_frame_parser");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("FAIL ubx_nav_pvt_frame_parser");
    $finish;
  end

endmodule

FILE: sim.f
hdl/ubxp_pkg.sv
hdl/ubxp_if.sv
hdl/ubx_nav_pvt_frame_parser.sv
hdl/ubxp_checker.sv
sim/testbench.sv
